>>> src/rbcr_pkg.sv
// Shared types and constants for the reflective bar code reader.
// Used by every module of the block; depends on nothing else.
package rbcr_pkg;

  localparam int CODE_BITS = 13;
  localparam int SAMPLE_W = 10;
  localparam int TICK_W = 16;
  localparam int COUNT_W = 4;
  localparam int PAY_W = CODE_BITS - 3;
  localparam int MIN_W = SAMPLE_W + 1;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = TICK_W;

  localparam logic [MIN_W-1:0] MIN_RESET = MIN_W'(1024);
  localparam logic [COUNT_W-1:0] BARS_FULL = COUNT_W'(CODE_BITS);

  localparam logic [SAMPLE_W-1:0] NO_CARD_RESET = SAMPLE_W'(200);
  localparam logic [SAMPLE_W-1:0] WHITE_RESET = SAMPLE_W'(950);
  localparam logic [SAMPLE_W-1:0] WIDE_RESET = SAMPLE_W'(500);
  localparam logic [SAMPLE_W-1:0] NARROW_RESET = SAMPLE_W'(850);
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(1000);

  localparam logic [CFG_IDX_W-1:0] REG_NO_CARD = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WIDE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NARROW = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 3'd4;

  typedef enum logic [1:0] {
    KIND_NARROW = 2'd0,
    KIND_WIDE = 2'd1,
    KIND_FAINT = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ORIENT_FORWARD = 2'd0,
    ORIENT_REVERSED = 2'd1,
    ORIENT_NONE = 2'd2
  } orient_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] no_card_level;
    logic [SAMPLE_W-1:0] white_level;
    logic [SAMPLE_W-1:0] wide_level;
    logic [SAMPLE_W-1:0] narrow_level;
    logic [TICK_W-1:0] timeout_ticks;
  } cfg_t;

  typedef struct packed {
    orient_t orientation;
    logic [PAY_W-1:0] payload;
    logic code_valid;
  } check_t;

  typedef struct packed {
    logic bar_done;
    kind_t bar_kind;
    logic [CODE_BITS-1:0] raw_code;
    logic enough_bars;
    check_t check;
    logic timeout_reset;
  } result_t;

endpackage

>>> src/rbcr_decode.sv
// Orientation, payload extraction and parity check of one 13-bit code.
// Depends on rbcr_pkg.
module rbcr_decode
  import rbcr_pkg::*;
(
  input  logic [CODE_BITS-1:0] code,
  output check_t               check
);

  logic [CODE_BITS-1:0] reversed;
  logic [CODE_BITS-1:0] oriented;
  logic                 par;

  always_comb begin
    for (int i = 0; i < CODE_BITS; i++) begin
      reversed[CODE_BITS-1-i] = code[i];
    end
  end

  always_comb begin
    if (code[2:0] == 3'b000) begin
      check.orientation = ORIENT_FORWARD;
      oriented = code;
    end else if (code[CODE_BITS-1:CODE_BITS-3] == 3'b000) begin
      check.orientation = ORIENT_REVERSED;
      oriented = reversed;
    end else begin
      check.orientation = ORIENT_NONE;
      oriented = code;
    end
    check.payload = oriented[CODE_BITS-1:3];
    par = ^check.payload[PAY_W-1:3];
    check.code_valid = (check.payload[7] == par) && ((check.payload[8] ^ par) == 1'b1)
                       && check.payload[9];
  end

endmodule

>>> src/rbcr_core.sv
// Tracking state of the reader: sample classes, bar minimum, shift code,
// bar count and timeout. Depends on rbcr_pkg and rbcr_decode.
module rbcr_core
  import rbcr_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  cfg_t                cfg,
  input  logic                fire,
  input  logic [SAMPLE_W-1:0] sample,
  output result_t             result
);

  logic [CODE_BITS-1:0] shift_code, shift_code_next;
  logic [MIN_W-1:0]     bar_minimum, bar_minimum_next;
  logic                 in_bar, in_bar_next;
  logic                 white_seen, white_seen_next;
  logic [COUNT_W-1:0]   bars_seen, bars_seen_next;
  logic [TICK_W-1:0]    ticks_since_bar, ticks_since_bar_next;

  logic [TICK_W-1:0]    tick_inc;
  logic                 tmo;
  logic [CODE_BITS-1:0] shift_pre, shift_bar;
  logic [COUNT_W-1:0]   bars_pre, bars_bar;
  logic                 no_card, is_white, bar_end, wide, narrow, enough;
  kind_t                kind;
  check_t               check;

  rbcr_decode u_decode (
    .code  (shift_bar),
    .check (check)
  );

  always_comb begin
    tick_inc = (ticks_since_bar != '1) ? ticks_since_bar + TICK_W'(1) : ticks_since_bar;
    tmo = (tick_inc > cfg.timeout_ticks) && (bars_seen != '0);
    shift_pre = tmo ? '1 : shift_code;
    bars_pre = tmo ? '0 : bars_seen;

    no_card = sample < cfg.no_card_level;
    is_white = !no_card && (sample > cfg.white_level);
    bar_end = is_white && in_bar;
    wide = bar_minimum < {1'b0, cfg.wide_level};
    narrow = bar_minimum < {1'b0, cfg.narrow_level};

    if (wide) begin
      kind = KIND_WIDE;
      shift_bar = {shift_pre[CODE_BITS-2:0], 1'b1};
    end else if (narrow) begin
      kind = KIND_NARROW;
      shift_bar = {shift_pre[CODE_BITS-2:0], 1'b0};
    end else begin
      kind = KIND_FAINT;
      shift_bar = shift_pre;
    end
    bars_bar = (bars_pre < BARS_FULL) ? bars_pre + COUNT_W'(1) : bars_pre;
    enough = bars_bar >= BARS_FULL;

    result.timeout_reset = tmo;
    result.bar_done = bar_end;
    result.bar_kind = bar_end ? kind : KIND_NARROW;
    result.raw_code = bar_end ? shift_bar : '0;
    result.enough_bars = bar_end && enough;
    if (bar_end && enough) begin
      result.check = check;
    end else begin
      result.check = '{orientation: ORIENT_FORWARD, payload: '0, code_valid: 1'b0};
    end

    shift_code_next = shift_pre;
    bars_seen_next = bars_pre;
    ticks_since_bar_next = tick_inc;
    in_bar_next = in_bar;
    white_seen_next = white_seen;
    bar_minimum_next = bar_minimum;
    if (no_card) begin
      in_bar_next = 1'b0;
      bar_minimum_next = MIN_RESET;
      white_seen_next = 1'b0;
    end else if (is_white) begin
      white_seen_next = 1'b1;
      if (in_bar) begin
        shift_code_next = shift_bar;
        bars_seen_next = bars_bar;
        ticks_since_bar_next = '0;
        if (enough && check.code_valid) begin
          shift_code_next = '1;
          bars_seen_next = '0;
        end
        in_bar_next = 1'b0;
        bar_minimum_next = MIN_RESET;
      end
    end else if (white_seen) begin
      in_bar_next = 1'b1;
      if ({1'b0, sample} < bar_minimum) begin
        bar_minimum_next = {1'b0, sample};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      shift_code <= '1;
      bar_minimum <= MIN_RESET;
      in_bar <= 1'b0;
      white_seen <= 1'b0;
      bars_seen <= '0;
      ticks_since_bar <= '0;
    end else if (fire) begin
      shift_code <= shift_code_next;
      bar_minimum <= bar_minimum_next;
      in_bar <= in_bar_next;
      white_seen <= white_seen_next;
      bars_seen <= bars_seen_next;
      ticks_since_bar <= ticks_since_bar_next;
    end
  end

endmodule

>>> src/reflective_bar_code_reader.sv
// Top level of the reflective bar code reader: configuration registers,
// input register, tracking core and result register. Depends on rbcr_pkg
// and rbcr_core.
//
// Usage: each transaction on the input channel (in_valid, in_ready, sample)
// carries one reflectance sample for one tick. Each accepted sample yields
// exactly one transaction on the result channel (out_valid, out_ready and
// the result fields), in order.
// Path: an accepted sample is registered in the input register, processed
// by the tracking core, and its result is registered in the result register,
// which out_valid presents. Throughput is one sample per cycle while out_ready
// is high; the loop through the tracking state sets that figure.
// Stalls: when the receiver holds out_ready low, the result register holds
// its value, one more sample may wait in the input register, and in_ready
// then falls until the result is taken.
// Configuration: cfg_we writes cfg_data to register cfg_index at the clock
// edge (0 no card level, 1 white level, 2 wide level, 3 narrow level,
// 4 timeout ticks); other indexes are ignored. Write only while idle.
// Reset: rst clears both channels, restores the default thresholds and
// returns the tracking state to no bars and an all-ones shift code.
module reflective_bar_code_reader
  import rbcr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [SAMPLE_W-1:0]   sample,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  bar_done,
  output logic [1:0]            bar_kind,
  output logic [CODE_BITS-1:0]  raw_code,
  output logic                  enough_bars,
  output logic [1:0]            orientation,
  output logic [PAY_W-1:0]      payload,
  output logic                  code_valid,
  output logic                  timeout_reset
);

  cfg_t                cfg;
  logic                hold_valid;
  logic [SAMPLE_W-1:0] hold_sample;
  logic                move;
  logic                fire;
  result_t             result;
  result_t             out_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.no_card_level <= NO_CARD_RESET;
      cfg.white_level <= WHITE_RESET;
      cfg.wide_level <= WIDE_RESET;
      cfg.narrow_level <= NARROW_RESET;
      cfg.timeout_ticks <= TIMEOUT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_NO_CARD: cfg.no_card_level <= cfg_data[SAMPLE_W-1:0];
        REG_WHITE:   cfg.white_level <= cfg_data[SAMPLE_W-1:0];
        REG_WIDE:    cfg.wide_level <= cfg_data[SAMPLE_W-1:0];
        REG_NARROW:  cfg.narrow_level <= cfg_data[SAMPLE_W-1:0];
        REG_TIMEOUT: cfg.timeout_ticks <= cfg_data[TICK_W-1:0];
        default: ;
      endcase
    end
  end

  assign move = !out_valid || out_ready;
  assign fire = hold_valid && move;
  assign in_ready = !hold_valid || move;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_sample <= sample;
    end
  end

  rbcr_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .fire   (fire),
    .sample (hold_sample),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (move) begin
      out_valid <= hold_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_result <= result;
    end
  end

  assign bar_done = out_result.bar_done;
  assign bar_kind = out_result.bar_kind;
  assign raw_code = out_result.raw_code;
  assign enough_bars = out_result.enough_bars;
  assign orientation = out_result.check.orientation;
  assign payload = out_result.check.payload;
  assign code_valid = out_result.check.code_valid;
  assign timeout_reset = out_result.timeout_reset;

endmodule

>>> src/rbcr_checker.sv
// Port-level checks of the reflective bar code reader, bound to the top level.
// Depends on rbcr_pkg and reflective_bar_code_reader.
module rbcr_checker
  import rbcr_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic                 bar_done,
  input logic [1:0]           bar_kind,
  input logic [CODE_BITS-1:0] raw_code,
  input logic                 enough_bars,
  input logic [1:0]           orientation,
  input logic [PAY_W-1:0]     payload,
  input logic                 code_valid
);

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(raw_code) && $stable(payload))
    else $error("result changed while stalled");

  a_no_bar_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bar_done |-> bar_kind == KIND_NARROW && raw_code == '0 && !enough_bars)
    else $error("bar fields set without a finished bar");

  a_few_bars_quiet: assert property (@(posedge clk) disable iff (rst)
    out_valid && !enough_bars |-> orientation == ORIENT_FORWARD && payload == '0
      && !code_valid)
    else $error("code fields set with too few bars");

  a_valid_code: assert property (@(posedge clk) disable iff (rst)
    out_valid && code_valid |-> enough_bars && bar_done && payload[PAY_W-1])
    else $error("valid code without a finished bar and leading one");

endmodule

bind reflective_bar_code_reader rbcr_checker u_rbcr_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .bar_done    (bar_done),
  .bar_kind    (bar_kind),
  .raw_code    (raw_code),
  .enough_bars (enough_bars),
  .orientation (orientation),
  .payload     (payload),
  .code_valid  (code_valid)
);
